// File: src/slpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pattern replacer package
// Shared types, register indexes and sizing constants.
// ----------------------------------------------------------------------------
package slpr_pkg;

   typedef logic [7:0] byte_type;

   // Largest pattern the register layout can describe.
   localparam int MAX_PATTERN      = 16;
   localparam int PATTERN_BYTES_DEF = 16;

   localparam int LEN_W   = 5;
   localparam int DATA_W  = 64;
   localparam int COUNT_W = 16;
   localparam int INDEX_W = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [INDEX_W-1:0] REG_PATTERN_LEN  = 3'd0;
   localparam logic [INDEX_W-1:0] REG_SEARCH_LOW   = 3'd1;
   localparam logic [INDEX_W-1:0] REG_SEARCH_HIGH  = 3'd2;
   localparam logic [INDEX_W-1:0] REG_REPLACE_LOW  = 3'd3;
   localparam logic [INDEX_W-1:0] REG_REPLACE_HIGH = 3'd4;

endpackage

// File: src/slpr_head_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Head match and patch
// Compares the first len bytes of the window with the search string and
// produces the window head with the replacement string laid over it.
// ----------------------------------------------------------------------------
module slpr_head_match #(
   parameter int PATTERN_BYTES = slpr_pkg::PATTERN_BYTES_DEF
) (
   input  slpr_pkg::byte_type [PATTERN_BYTES-1:0]         head,
   input  logic [$clog2(PATTERN_BYTES+2)-1:0]             len,
   input  slpr_pkg::byte_type [slpr_pkg::MAX_PATTERN-1:0] search_bytes,
   input  slpr_pkg::byte_type [slpr_pkg::MAX_PATTERN-1:0] replace_bytes,
   output logic                                           hit,
   output slpr_pkg::byte_type [PATTERN_BYTES-1:0]         patched
);

   localparam int FILL_W = $clog2(PATTERN_BYTES + 2);

   logic [PATTERN_BYTES-1:0] byte_ok;

   always_comb begin
      for (int k = 0; k < PATTERN_BYTES; k++) begin
         // Positions at or past the pattern length do not take part.
         if (FILL_W'(k) >= len) begin
            byte_ok[k] = 1'b1;
            patched[k] = head[k];
         end else begin
            byte_ok[k] = (head[k] == search_bytes[k]);
            patched[k] = replace_bytes[k];
         end
      end
      hit = &byte_ok;
   end

endmodule

// File: src/same_length_pattern_replacer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Same length pattern replacer
// Slides a window of pattern length plus one bytes over a byte stream and
// overwrites each occurrence of the search string with the replacement.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle when the result register has space and no flush
// or drain holds input, set by one head compare and shift per cycle. A byte
// leaves pattern_len beats later, through the result register. A final beat
// flushes the held bytes one per cycle as the output allows, stalling input until
// the flush ends; a beat after the length shrinks drains surplus held bytes alike.
// Reset: synchronous, active high; empties the window, clears count, strings and result valid.
// ----------------------------------------------------------------------------
module same_length_pattern_replacer #(
   parameter int PATTERN_BYTES = slpr_pkg::PATTERN_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              csr_write_en,
   input  logic [slpr_pkg::INDEX_W-1:0]      csr_index,
   input  logic [slpr_pkg::DATA_W-1:0]       csr_write_data,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_is_final,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_out_final,
   output logic [slpr_pkg::COUNT_W-1:0]      rsp_replace_count
);

   localparam int FILL_W = $clog2(PATTERN_BYTES + 2);
   localparam int LEN_W  = slpr_pkg::LEN_W;
   localparam int CNT_W  = slpr_pkg::COUNT_W;

   // Configuration registers.
   logic [LEN_W-1:0]                  pattern_len_ff;
   logic [slpr_pkg::DATA_W-1:0]       search_low_ff, search_high_ff;
   logic [slpr_pkg::DATA_W-1:0]       replace_low_ff, replace_high_ff;

   // Window state.
   slpr_pkg::byte_type [PATTERN_BYTES:0] win_ff, win_in;
   logic [FILL_W-1:0]                 fill_ff, fill_in;
   logic                              fin_ff, fin_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic                              busy_ff, busy_in;

   // Result register.
   logic                              rsp_valid_ff, rsp_valid_in;
   slpr_pkg::byte_type                rsp_byte_ff, rsp_byte_in;
   logic                              rsp_final_ff, rsp_final_in;
   logic [CNT_W-1:0]                  rsp_count_ff, rsp_count_in;

   logic [LEN_W-1:0]                  len_clip;
   logic [FILL_W-1:0]                 len_eff;
   logic                              accept, step;
   slpr_pkg::byte_type [PATTERN_BYTES:0]   v_win;
   slpr_pkg::byte_type [PATTERN_BYTES-1:0] head, patched;
   logic [FILL_W-1:0]                 v_fill;
   logic                              v_fin;
   logic                              out_space, over, tail_final;
   logic                              do_emit, do_test, hit, hit_use, last;
   logic [CNT_W-1:0]                  count_after;

   slpr_pkg::byte_type [slpr_pkg::MAX_PATTERN-1:0] search_bytes, replace_bytes;

   assign search_bytes  = {search_high_ff, search_low_ff};
   assign replace_bytes = {replace_high_ff, replace_low_ff};

   // Out-of-range lengths are clamped to the supported span.
   always_comb begin
      len_clip = pattern_len_ff;
      if (pattern_len_ff == '0) begin
         len_clip = LEN_W'(1);
      end else if (pattern_len_ff > LEN_W'(PATTERN_BYTES)) begin
         len_clip = LEN_W'(PATTERN_BYTES);
      end
      len_eff = FILL_W'(len_clip);
   end

   assign req_ready = !busy_ff && !fin_ff;
   assign accept    = req_valid && req_ready;
   assign out_space = !rsp_valid_ff || rsp_ready;
   // Draining only runs on behalf of an accepted beat, so a length change
   // takes effect with the next beat and the registers in force then.
   assign step      = accept || busy_ff;

   // The window as seen this cycle, with an accepted beat already inserted.
   always_comb begin
      for (int k = 0; k <= PATTERN_BYTES; k++) begin
         if (accept && (fill_ff == FILL_W'(k))) begin
            v_win[k] = req_data_byte;
         end else begin
            v_win[k] = win_ff[k];
         end
      end
      for (int k = 0; k < PATTERN_BYTES; k++) begin
         head[k] = v_win[k];
      end
   end

   assign v_fill = fill_ff + FILL_W'(accept);
   assign v_fin  = fin_ff | (accept & req_is_final);

   slpr_head_match #(
      .PATTERN_BYTES (PATTERN_BYTES)
   ) u_match (
      .head          (head),
      .len           (len_eff),
      .search_bytes  (search_bytes),
      .replace_bytes (replace_bytes),
      .hit           (hit),
      .patched       (patched)
   );

   always_comb begin
      over       = (v_fill > len_eff) && step;
      // A match may not end right before the final byte of the buffer.
      tail_final = v_fin && (v_fill == len_eff + FILL_W'(1));
      do_emit    = out_space && (over || v_fin);
      do_test    = do_emit && over && !tail_final;
      hit_use    = do_test && hit;
      last       = do_emit && !over && (v_fill == FILL_W'(1));

      count_after = count_ff;
      if (hit_use && (count_ff != slpr_pkg::COUNT_MAX)) begin
         count_after = count_ff + CNT_W'(1);
      end

      win_in   = v_win;
      fill_in  = v_fill;
      fin_in   = v_fin;
      count_in = count_after;

      if (do_emit) begin
         for (int k = 0; k < PATTERN_BYTES - 1; k++) begin
            win_in[k] = hit_use ? patched[k+1] : v_win[k+1];
         end
         win_in[PATTERN_BYTES-1] = v_win[PATTERN_BYTES];
         win_in[PATTERN_BYTES]   = '0;
         fill_in = v_fill - FILL_W'(1);
      end

      if (last) begin
         fin_in   = 1'b0;
         count_in = '0;
      end

      busy_in = step && (fill_in > len_eff);

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_final_in = rsp_final_ff;
      rsp_count_in = rsp_count_ff;
      if (do_emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = hit_use ? patched[0] : v_win[0];
         rsp_final_in = last;
         rsp_count_in = count_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_len_ff  <= LEN_W'(1);
         search_low_ff   <= '0;
         search_high_ff  <= '0;
         replace_low_ff  <= '0;
         replace_high_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            slpr_pkg::REG_PATTERN_LEN: begin
               pattern_len_ff <= csr_write_data[LEN_W-1:0];
            end
            slpr_pkg::REG_SEARCH_LOW: begin
               search_low_ff <= csr_write_data;
            end
            slpr_pkg::REG_SEARCH_HIGH: begin
               search_high_ff <= csr_write_data;
            end
            slpr_pkg::REG_REPLACE_LOW: begin
               replace_low_ff <= csr_write_data;
            end
            slpr_pkg::REG_REPLACE_HIGH: begin
               replace_high_ff <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         fin_ff       <= 1'b0;
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         fin_ff       <= fin_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff       <= win_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_final_ff <= rsp_final_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_out_final     = rsp_final_ff;
   assign rsp_replace_count = rsp_count_ff;

endmodule

// File: tb/sv/slpr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pattern replacer checker
// Watches the register port and both streams of the pattern replacer. It keeps
// its own copy of the window and registers, predicts every patched beat, and
// compares each delivered beat with the oldest prediction.
// ----------------------------------------------------------------------------
module slpr_checker #(
   parameter int PATTERN_BYTES = slpr_pkg::PATTERN_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         csr_write_en,
   input  logic [slpr_pkg::INDEX_W-1:0] csr_index,
   input  logic [slpr_pkg::DATA_W-1:0]  csr_write_data,

   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [7:0]                   req_data_byte,
   input  logic                         req_is_final,

   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [7:0]                   rsp_out_byte,
   input  logic                         rsp_out_final,
   input  logic [slpr_pkg::COUNT_W-1:0] rsp_replace_count,

   output int                           mismatch_count,
   output int                           pending_beats,
   output int                           checked_beats
);

   typedef struct packed {
      logic [7:0]                   data;
      logic                         last;
      logic [slpr_pkg::COUNT_W-1:0] count;
   } patched_beat_type;

   patched_beat_type expected_beats [$];

   slpr_pkg::byte_type           window [0:slpr_pkg::MAX_PATTERN];
   int unsigned                  held;
   logic [slpr_pkg::COUNT_W-1:0] hits;

   logic [slpr_pkg::LEN_W-1:0]   len_reg;
   logic [slpr_pkg::DATA_W-1:0]  search_lo, search_hi, replace_lo, replace_hi;

   function automatic int unsigned active_len();
      int unsigned n;
      n = len_reg;
      if (n < 1) n = 1;
      if (n > PATTERN_BYTES) n = PATTERN_BYTES;
      return n;
   endfunction

   function automatic slpr_pkg::byte_type string_byte(
         input logic [slpr_pkg::DATA_W-1:0] lo,
         input logic [slpr_pkg::DATA_W-1:0] hi,
         input int unsigned k);
      if (k < 8) return lo[8*k +: 8];
      return hi[8*(k-8) +: 8];
   endfunction

   // Compares the oldest len bytes with the search string and overwrites
   // them in place on a hit.
   task automatic replace_at_head(input int unsigned len);
      bit hit;
      hit = 1'b1;
      for (int unsigned k = 0; k < len; k++) begin
         if (window[k] != string_byte(search_lo, search_hi, k)) hit = 1'b0;
      end
      if (hit) begin
         for (int unsigned k = 0; k < len; k++) begin
            window[k] = string_byte(replace_lo, replace_hi, k);
         end
         if (hits != slpr_pkg::COUNT_MAX) hits++;
      end
   endtask

   task automatic emit_head(input logic last);
      patched_beat_type beat;
      beat.data  = window[0];
      beat.last  = last;
      beat.count = hits;
      expected_beats.push_back(beat);
      if (held > 0) begin
         for (int unsigned k = 0; k + 1 < held; k++) window[k] = window[k+1];
         held--;
         window[held] = '0;
      end
   endtask

   task automatic predict_patched_beats(input slpr_pkg::byte_type data,
                                        input logic last);
      int unsigned len;
      bit tail_is_final;
      len = active_len();
      if (held > slpr_pkg::MAX_PATTERN) held = slpr_pkg::MAX_PATTERN;
      window[held] = data;
      held++;
      // A shorter length drains several positions on one input beat.
      while (held >= len + 1) begin
         tail_is_final = last && (held - 1 == len);
         if (!tail_is_final) replace_at_head(len);
         emit_head(1'b0);
      end
      if (last) begin
         while (held > 0) emit_head(held == 1);
         held = 0;
         hits = '0;
      end
   endtask

   always @(posedge clock) begin
      patched_beat_type want;
      if (reset) begin
         for (int k = 0; k <= slpr_pkg::MAX_PATTERN; k++) window[k] = '0;
         held           = 0;
         hits           = '0;
         len_reg        = slpr_pkg::LEN_W'(1);
         search_lo      = '0;
         search_hi      = '0;
         replace_lo     = '0;
         replace_hi     = '0;
         expected_beats.delete();
         mismatch_count = 0;
         checked_beats  = 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               slpr_pkg::REG_PATTERN_LEN:  len_reg    = csr_write_data[slpr_pkg::LEN_W-1:0];
               slpr_pkg::REG_SEARCH_LOW:   search_lo  = csr_write_data;
               slpr_pkg::REG_SEARCH_HIGH:  search_hi  = csr_write_data;
               slpr_pkg::REG_REPLACE_LOW:  replace_lo = csr_write_data;
               slpr_pkg::REG_REPLACE_HIGH: replace_hi = csr_write_data;
               default: ;
            endcase
         end

         if (req_valid && req_ready) predict_patched_beats(req_data_byte, req_is_final);

         if (rsp_valid && rsp_ready) begin
            checked_beats++;
            if (expected_beats.size() == 0) begin
               $display("%0t: unexpected beat, expected none, got byte %h final %b count %0d",
                        $time, rsp_out_byte, rsp_out_final, rsp_replace_count);
               mismatch_count++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_out_byte !== want.data) begin
                  $display("%0t: out_byte mismatch, expected %h, got %h",
                           $time, want.data, rsp_out_byte);
                  mismatch_count++;
               end
               if (rsp_out_final !== want.last) begin
                  $display("%0t: out_final mismatch, expected %b, got %b",
                           $time, want.last, rsp_out_final);
                  mismatch_count++;
               end
               if (rsp_replace_count !== want.count) begin
                  $display("%0t: replace_count mismatch, expected %0d, got %0d",
                           $time, want.count, rsp_replace_count);
                  mismatch_count++;
               end
            end
         end
      end
      pending_beats = expected_beats.size();
   end

endmodule

// File: tb/sv/same_length_pattern_replacer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pattern replacer testbench
// Drives byte buffers and register writes into the pattern replacer: directed
// corner cases, then randomized buffers under four mixes of sender gaps and
// receiver stalls. A checker beside the block predicts and compares every
// patched beat.
// ----------------------------------------------------------------------------
module same_length_pattern_replacer_tb;

   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS   = 72;

   logic                         clock          = 1'b0;
   logic                         reset          = 1'b1;
   logic                         csr_write_en   = 1'b0;
   logic [slpr_pkg::INDEX_W-1:0] csr_index      = '0;
   logic [slpr_pkg::DATA_W-1:0]  csr_write_data = '0;
   logic                         req_valid      = 1'b0;
   logic                         req_ready;
   logic [7:0]                   req_data_byte  = '0;
   logic                         req_is_final   = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready      = 1'b0;
   logic [7:0]                   rsp_out_byte;
   logic                         rsp_out_final;
   logic [slpr_pkg::COUNT_W-1:0] rsp_replace_count;

   int mismatch_count;
   int pending_beats;
   int checked_beats;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int items_sent     = 0;
   int buffers_sent   = 0;

   slpr_pkg::byte_type cur_search  [0:slpr_pkg::MAX_PATTERN-1];
   slpr_pkg::byte_type cur_replace [0:slpr_pkg::MAX_PATTERN-1];
   int                 cur_len = 1;

   same_length_pattern_replacer dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_is_final      (req_is_final),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_out_final     (rsp_out_final),
      .rsp_replace_count (rsp_replace_count)
   );

   slpr_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_is_final      (req_is_final),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_out_final     (rsp_out_final),
      .rsp_replace_count (rsp_replace_count),
      .mismatch_count    (mismatch_count),
      .pending_beats     (pending_beats),
      .checked_beats     (checked_beats)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // All tasks start and end at a falling edge.
   task automatic write_reg(input logic [slpr_pkg::INDEX_W-1:0] idx,
                            input logic [slpr_pkg::DATA_W-1:0]  value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   task automatic set_length(input int raw);
      write_reg(slpr_pkg::REG_PATTERN_LEN, slpr_pkg::DATA_W'(raw));
      cur_len = (raw == 0) ? 1 :
                (raw > slpr_pkg::MAX_PATTERN) ? slpr_pkg::MAX_PATTERN : raw;
   endtask

   task automatic load_strings();
      logic [slpr_pkg::DATA_W-1:0] s_lo, s_hi, r_lo, r_hi;
      for (int k = 0; k < 8; k++) begin
         s_lo[8*k +: 8] = cur_search[k];
         s_hi[8*k +: 8] = cur_search[k+8];
         r_lo[8*k +: 8] = cur_replace[k];
         r_hi[8*k +: 8] = cur_replace[k+8];
      end
      write_reg(slpr_pkg::REG_SEARCH_LOW, s_lo);
      write_reg(slpr_pkg::REG_SEARCH_HIGH, s_hi);
      write_reg(slpr_pkg::REG_REPLACE_LOW, r_lo);
      write_reg(slpr_pkg::REG_REPLACE_HIGH, r_hi);
   endtask

   // Valid stays high across back-to-back beats and only drops for a gap.
   task automatic send_byte(input logic [7:0] data, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_is_final  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
      if (last) buffers_sent++;
   endtask

   // Registers only change once every predicted beat is out and the block
   // has had time to finish any flush.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_beats != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic random_buffer();
      int unsigned        sel, mode, n_bytes;
      int                 raw_len;
      slpr_pkg::byte_type pool_a, pool_b, data;
      settle();
      sel = $urandom_range(99);
      if (sel < 60)      raw_len = $urandom_range(4, 1);
      else if (sel < 85) raw_len = $urandom_range(16, 5);
      else if (sel < 90) raw_len = 0;
      else               raw_len = $urandom_range(31, 17);
      set_length(raw_len);

      // A two-symbol alphabet makes hits and partial hits common.
      pool_a = 8'($urandom);
      pool_b = 8'($urandom);
      for (int k = 0; k < slpr_pkg::MAX_PATTERN; k++) begin
         cur_search[k] = $urandom_range(1) ? pool_a : pool_b;
      end
      mode = $urandom_range(3);
      for (int k = 0; k < slpr_pkg::MAX_PATTERN; k++) begin
         case (mode)
            0:       cur_replace[k] = 8'($urandom);
            1:       cur_replace[k] = $urandom_range(1) ? pool_a : pool_b;
            2:       cur_replace[k] = cur_search[k];
            default: cur_replace[k] = cur_search[(k + 1) % slpr_pkg::MAX_PATTERN];
         endcase
      end
      load_strings();

      if ($urandom_range(99) < 15) n_bytes = $urandom_range(cur_len + 1, 1);
      else                         n_bytes = $urandom_range(3 * cur_len + 12, cur_len + 2);

      for (int unsigned i = 0; i < n_bytes; i++) begin
         if (i != 0 && $urandom_range(99) < 3) begin
            settle();
            if ($urandom_range(1)) begin
               set_length($urandom_range(31, 0));
            end else begin
               cur_replace[$urandom_range(slpr_pkg::MAX_PATTERN - 1)] = 8'($urandom);
               cur_search[$urandom_range(slpr_pkg::MAX_PATTERN - 1)]  = pool_a;
               load_strings();
            end
         end
         sel = $urandom_range(99);
         if (sel < 40)      data = cur_search[i % cur_len];
         else if (sel < 60) data = cur_search[$urandom_range(cur_len - 1)];
         else if (sel < 75) data = cur_replace[$urandom_range(cur_len - 1)];
         else               data = 8'($urandom);
         send_byte(data, i == n_bytes - 1);
      end
   endtask

   initial begin
      int guard;
      int phase_start;
      for (int k = 0; k < slpr_pkg::MAX_PATTERN; k++) begin
         cur_search[k]  = '0;
         cur_replace[k] = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Registers at their reset values; a buffer of length plus one bytes
      // cannot match.
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);

      // A length of zero behaves as one; the match touching the final byte
      // does not count.
      settle();
      set_length(0);
      cur_search[0]  = 8'h41;
      cur_replace[0] = 8'hBE;
      load_strings();
      repeat (3) send_byte(8'h41, 1'b0);
      send_byte(8'h41, 1'b1);

      // A length above the maximum behaves as the maximum; all-ones and
      // all-zeros bytes in both strings.
      settle();
      set_length(31);
      for (int k = 0; k < slpr_pkg::MAX_PATTERN; k++) begin
         cur_search[k]  = (k % 2 == 0) ? 8'hFF : 8'h00;
         cur_replace[k] = (k % 2 == 0) ? 8'h00 : 8'hFF;
      end
      load_strings();
      for (int k = 0; k < slpr_pkg::MAX_PATTERN; k++) send_byte(cur_search[k], 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'hA5, 1'b1);

      // Replacement in place feeds the next candidate, then the length and
      // the strings change while bytes are still held.
      settle();
      set_length(2);
      cur_search[0]  = 8'h41;
      cur_search[1]  = 8'h41;
      cur_replace[0] = 8'h00;
      cur_replace[1] = 8'h41;
      load_strings();
      repeat (3) send_byte(8'h41, 1'b0);
      settle();
      set_length(1);
      cur_replace[0] = 8'h7E;
      load_strings();
      send_byte(8'h41, 1'b0);
      send_byte(8'h41, 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
         endcase
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) random_buffer();
      end

      req_valid <= 1'b0;
      guard = 0;
      while (pending_beats != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_beats != 0) begin
         $display("%0t: %0d predicted beats never arrived", $time, pending_beats);
      end

      $display("Sent %0d buffers with %0d input beats and checked %0d patched beats,",
               buffers_sent, items_sent, checked_beats);
      $display("covering corner lengths, mid-buffer register changes",
               " and four gap/stall mixes.");
      if (mismatch_count == 0 && pending_beats == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("%0t: run timed out", $time);
      $display("Some tests failed");
      $finish;
   end

endmodule

// File: filelist.f
src/slpr_pkg.sv
src/slpr_head_match.sv
src/same_length_pattern_replacer.sv
tb/sv/slpr_checker.sv
tb/sv/same_length_pattern_replacer_tb.sv
